[sv/mcdbr_pkg.sv]
package mcdbr_pkg;

   localparam int OUT_BITS = 4;
   localparam int LEVEL_BITS = 4;

   localparam logic [1:0] MODE_EDGE = 2'd0;
   localparam logic [1:0] MODE_POLL = 2'd1;
   localparam logic [1:0] MODE_SET  = 2'd2;

   localparam logic [1:0] CSR_EDGE_LOCKOUT_US    = 2'd0;
   localparam logic [1:0] CSR_PRESS_LOCKOUT_MS   = 2'd1;
   localparam logic [1:0] CSR_RELAY_ACTIVE_LEVEL = 2'd2;

   localparam logic [31:0] EDGE_LOCKOUT_US_RESET  = 32'd50000;
   localparam logic [31:0] PRESS_LOCKOUT_MS_RESET = 32'd50;
   localparam logic        RELAY_ACTIVE_RESET     = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  channel;
      logic        relay_on;
      logic [3:0]  button_levels;
      logic [31:0] time_us;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic        press_valid;
      logic [1:0]  press_channel;
      logic [3:0]  relay_states;
      logic [3:0]  relay_levels;
   } rsp_type;

   typedef struct packed {
      logic [31:0] edge_lockout_us;
      logic [31:0] press_lockout_ms;
      logic        relay_active_level;
   } cfg_type;

   typedef struct packed {
      logic found;
   } scan_link_type;

endpackage

[sv/multi_channel_button_debounce_relay.sv]
// Button debouncer and relay latch, one cell per channel.
// Request channel (req_valid/req_ready/req_data): each transfer carries a mode.
//   Edge: a falling edge on one channel, taken if the edge lockout in us has
//   passed since that channel's last taken edge; it marks a press pending.
//   Poll: channels are scanned from 0 upward; pending flags reached are
//   cleared, and the first one that is low and out of press lockout is reported.
//   Set: latches one relay on or off.
// Response channel (rsp_valid/rsp_ready/rsp_data): one transfer per request,
//   with the press found and the relay states and driven pin levels.
// Each result is registered in the output entry, or first in the skid entry if the output entry is held.
// Throughput: one request per cycle while req_ready is high; the cell row settles
//   all channels in the cycle of the transfer, the poll priority rippling through the row.
// A two-entry output stage holds results while rsp_ready is low; req_ready
//   drops only once both entries are full.
// Configuration (csr_*): lockouts and relay active level, written while idle.
// Reset: relays off, no pending presses, all time stamps zero, configuration
//   back to 50000 us, 50 ms and active high.
module multi_channel_button_debounce_relay #(
   parameter int CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mcdbr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mcdbr_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import mcdbr_pkg::*;

   cfg_type       cfg_ff;
   scan_link_type link [CHANNELS+1];
   logic [CHANNELS-1:0] hit;
   logic [CHANNELS-1:0] relay_next;
   logic [CHANNELS-1:0] relay_state;
   logic          fire;
   logic          take;
   rsp_type       result;
   logic [1:0]    press_channel;
   rsp_type       out_ff, skid_ff;
   logic          out_valid_ff, skid_valid_ff;

   assign fire = req_valid && req_ready;
   assign take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_lockout_us    <= EDGE_LOCKOUT_US_RESET;
         cfg_ff.press_lockout_ms   <= PRESS_LOCKOUT_MS_RESET;
         cfg_ff.relay_active_level <= RELAY_ACTIVE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EDGE_LOCKOUT_US:    cfg_ff.edge_lockout_us    <= csr_wdata;
            CSR_PRESS_LOCKOUT_MS:   cfg_ff.press_lockout_ms   <= csr_wdata;
            CSR_RELAY_ACTIVE_LEVEL: cfg_ff.relay_active_level <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign link[0].found = 1'b0;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
      logic level;
      if (i < LEVEL_BITS) begin : g_level
         assign level = req_data.button_levels[i];
      end else begin : g_nolevel
         assign level = 1'b0;
      end
      mcdbr_cell #(
         .INDEX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .fire        (fire),
         .req_data    (req_data),
         .level       (level),
         .cfg         (cfg_ff),
         .link_in     (link[i]),
         .link_out    (link[i+1]),
         .hit         (hit[i]),
         .relay_next  (relay_next[i]),
         .relay_state (relay_state[i])
      );
   end

   always_comb begin
      press_channel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (hit[i]) begin
            press_channel = press_channel | 2'(i);
         end
      end
   end

   for (genvar i = 0; i < OUT_BITS; i++) begin : g_out
      if (i < CHANNELS) begin : g_used
         assign result.relay_states[i] = relay_next[i];
         assign result.relay_levels[i] = relay_next[i] ? cfg_ff.relay_active_level
                                                       : ~cfg_ff.relay_active_level;
      end else begin : g_unused
         assign result.relay_states[i] = 1'b0;
         assign result.relay_levels[i] = 1'b0;
      end
   end

   assign result.press_valid   = link[CHANNELS].found;
   assign result.press_channel = press_channel;

   assign req_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (fire) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (fire) begin
         if (!out_valid_ff || take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit))
      else $error("poll reported more than one channel");

   a_relay_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(relay_state))
      else $error("relay state changed without a transfer");

   a_channel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.press_valid |-> rsp_data.press_channel == 2'd0)
      else $error("press channel set without a press");
`endif

endmodule

[sv/mcdbr_cell.sv]
module mcdbr_cell #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  mcdbr_pkg::req_type      req_data,
   input  logic                    level,
   input  mcdbr_pkg::cfg_type      cfg,
   input  mcdbr_pkg::scan_link_type link_in,
   output mcdbr_pkg::scan_link_type link_out,
   output logic                    hit,
   output logic                    relay_next,
   output logic                    relay_state
);
   import mcdbr_pkg::*;

   logic        relay_ff, relay_in;
   logic        pending_ff, pending_in;
   logic [31:0] last_edge_ff, last_edge_in;
   logic [31:0] last_press_ff, last_press_in;
   logic        chan_match;
   logic        edge_ok;
   logic        press_ok;
   logic [31:0] edge_delta;
   logic [31:0] press_delta;

   assign chan_match  = (req_data.channel == 4'(INDEX));
   assign edge_delta  = req_data.time_us - last_edge_ff;
   assign press_delta = req_data.time_ms - last_press_ff;
   assign edge_ok     = (edge_delta >= cfg.edge_lockout_us);
   assign press_ok    = (press_delta >= cfg.press_lockout_ms);

   always_comb begin
      relay_in      = relay_ff;
      pending_in    = pending_ff;
      last_edge_in  = last_edge_ff;
      last_press_in = last_press_ff;
      hit           = 1'b0;
      case (req_data.mode)
         MODE_EDGE: begin
            if (chan_match && edge_ok) begin
               last_edge_in = req_data.time_us;
               pending_in   = 1'b1;
            end
         end
         MODE_POLL: begin
            if (!link_in.found && pending_ff) begin
               pending_in = 1'b0;
               if (press_ok && !level) begin
                  hit           = 1'b1;
                  last_press_in = req_data.time_ms;
               end
            end
         end
         MODE_SET: begin
            if (chan_match) begin
               relay_in = req_data.relay_on;
            end
         end
         default: begin
         end
      endcase
   end

   assign link_out.found = link_in.found | hit;
   assign relay_next     = relay_in;
   assign relay_state    = relay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= 1'b0;
         pending_ff    <= 1'b0;
         last_edge_ff  <= '0;
         last_press_ff <= '0;
      end else if (fire) begin
         relay_ff      <= relay_in;
         pending_ff    <= pending_in;
         last_edge_ff  <= last_edge_in;
         last_press_ff <= last_press_in;
      end
   end

endmodule

[verif/press_relay_checker.sv]
`timescale 1ns / 100ps

module press_relay_checker #(
   parameter int CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  mcdbr_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  mcdbr_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 mismatches,
   output int                 expected_left
);
   import mcdbr_pkg::*;

   logic [31:0]         edge_lockout;
   logic [31:0]         press_lockout;
   logic                active_level;
   logic [CHANNELS-1:0] relay_latch;
   logic [CHANNELS-1:0] press_pending;
   logic [31:0]         last_edge_us [CHANNELS];
   logic [31:0]         last_press_ms [CHANNELS];
   rsp_type             press_report_q [$];
   int                  err_cnt;

   function automatic rsp_type predict_press(input req_type r);
      rsp_type     o;
      logic [31:0] gap;
      bit          found;
      o = '0;
      found = 1'b0;
      case (r.mode)
         MODE_EDGE: begin
            if (r.channel < CHANNELS) begin
               gap = r.time_us - last_edge_us[r.channel];
               if (gap >= edge_lockout) begin
                  last_edge_us[r.channel] = r.time_us;
                  press_pending[r.channel] = 1'b1;
               end
            end
         end
         MODE_POLL: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (!found && press_pending[i]) begin
                  press_pending[i] = 1'b0;
                  gap = r.time_ms - last_press_ms[i];
                  if (gap >= press_lockout && !r.button_levels[i]) begin
                     last_press_ms[i] = r.time_ms;
                     found = 1'b1;
                     o.press_valid = 1'b1;
                     o.press_channel = 2'(i);
                  end
               end
            end
         end
         MODE_SET: begin
            if (r.channel < CHANNELS) relay_latch[r.channel] = r.relay_on;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < CHANNELS && i < OUT_BITS; i++) begin
         o.relay_states[i] = relay_latch[i];
         o.relay_levels[i] = relay_latch[i] ? active_level : ~active_level;
      end
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         edge_lockout = EDGE_LOCKOUT_US_RESET;
         press_lockout = PRESS_LOCKOUT_MS_RESET;
         active_level = RELAY_ACTIVE_RESET;
         relay_latch = '0;
         press_pending = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_edge_us[i] = '0;
            last_press_ms[i] = '0;
         end
         press_report_q.delete();
         err_cnt = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (press_report_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("%0t: response with nothing expected: valid %b ch %0d st %b lv %b",
                     $realtime, rsp_data.press_valid, rsp_data.press_channel,
                     rsp_data.relay_states, rsp_data.relay_levels);
            end else begin
               want = press_report_q.pop_front();
               if (want.press_valid !== rsp_data.press_valid
                     || want.press_channel !== rsp_data.press_channel
                     || want.relay_states !== rsp_data.relay_states
                     || want.relay_levels !== rsp_data.relay_levels) begin
                  err_cnt++;
                  if (err_cnt <= 10)
                     $display("%0t: mismatch: exp %b/%0d/%b/%b got %b/%0d/%b/%b", $realtime,
                        want.press_valid, want.press_channel, want.relay_states,
                        want.relay_levels, rsp_data.press_valid, rsp_data.press_channel,
                        rsp_data.relay_states, rsp_data.relay_levels);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_EDGE_LOCKOUT_US:    edge_lockout = csr_wdata;
               CSR_PRESS_LOCKOUT_MS:   press_lockout = csr_wdata;
               CSR_RELAY_ACTIVE_LEVEL: active_level = csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) press_report_q.push_back(predict_press(req_data));
      end
      mismatches <= err_cnt;
      expected_left <= press_report_q.size();
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import mcdbr_pkg::*;

   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam int         RSP_HOLD_CYCLES = 300;
   localparam int         QUIET_LIMIT     = 5000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_EDGE_LOCKOUT_US;
   logic [31:0] csr_wdata = '0;

   int          mismatches;
   int          expected_left;
   logic [31:0] now_us = '0;
   logic [31:0] now_ms = '0;
   int unsigned us_step = 20000;
   int unsigned ms_step = 20;
   bit          no_idle = 1'b0;
   int          hold_requests = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   multi_channel_button_debounce_relay uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   press_relay_checker press_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   function automatic req_type button_req(input logic [1:0] mode, input logic [3:0] ch,
         input logic on, input logic [3:0] levels, input logic [31:0] tus,
         input logic [31:0] tms);
      req_type r;
      r.mode = mode;
      r.channel = ch;
      r.relay_on = on;
      r.button_levels = levels;
      r.time_us = tus;
      r.time_ms = tms;
      return r;
   endfunction

   function automatic req_type random_button_req();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) r.mode = MODE_EDGE;
      else if (pick < 70) r.mode = MODE_POLL;
      else if (pick < 95) r.mode = MODE_SET;
      else r.mode = MODE_UNUSED;
      r.channel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15))
                                               : 4'($urandom_range(0, 3));
      r.relay_on = 1'($urandom_range(0, 1));
      r.button_levels = 4'($urandom) & 4'($urandom);
      now_us = now_us + $urandom_range(0, us_step);
      now_ms = now_ms + $urandom_range(0, ms_step);
      r.time_us = ($urandom_range(0, 19) == 0) ? $urandom : now_us;
      r.time_ms = ($urandom_range(0, 19) == 0) ? $urandom : now_ms;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      if (!no_idle && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [31:0] lock_us, input logic [31:0] lock_ms,
         input logic level);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_EDGE_LOCKOUT_US;
      csr_wdata <= lock_us;
      @(posedge clock);
      csr_index <= CSR_PRESS_LOCKOUT_MS;
      csr_wdata <= lock_ms;
      @(posedge clock);
      csr_index <= CSR_RELAY_ACTIVE_LEVEL;
      csr_wdata <= {31'd0, level};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      us_step = lock_us / 2 + 3;
      ms_step = lock_ms / 2 + 3;
   endtask

   task automatic run_phase(input logic [31:0] lock_us, input logic [31:0] lock_ms,
         input logic level, input int count, input bit quiet, input bit squeeze,
         input bit mid_drain);
      wait_drained();
      set_thresholds(lock_us, lock_ms, level);
      no_idle = quiet;
      if (squeeze) hold_requests++;
      for (int k = 0; k < count; k++) begin
         if (mid_drain && k == count / 2) wait_drained();
         send_request(random_button_req());
      end
      no_idle = 1'b0;
   endtask

   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_seen != hold_requests) begin
            hold_seen++;
            hold_left = RSP_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL multi_channel_button_debounce_relay");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // lockout boundaries at reset thresholds
      send_request(button_req(MODE_EDGE, 4'd0, 1'b0, 4'h0, 32'd0, 32'd0));
      send_request(button_req(MODE_EDGE, 4'd0, 1'b0, 4'h0, 32'd50000, 32'd0));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'h0, 32'd0, 32'd10));
      send_request(button_req(MODE_EDGE, 4'd1, 1'b0, 4'h0, 32'hFFFF_FFFF, 32'd0));
      send_request(button_req(MODE_EDGE, 4'd2, 1'b0, 4'h0, 32'd60000, 32'd0));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'b0010, 32'd0, 32'd100));
      // out of range channels and the unused mode
      send_request(button_req(MODE_EDGE, 4'd15, 1'b1, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(button_req(MODE_SET, 4'd15, 1'b1, 4'hF, 32'd0, 32'd0));
      send_request(button_req(MODE_SET, 4'd0, 1'b1, 4'h0, 32'd0, 32'd0));
      send_request(button_req(MODE_SET, 4'd3, 1'b1, 4'h0, 32'd0, 32'd0));
      send_request(button_req(MODE_SET, 4'd3, 1'b0, 4'h0, 32'd0, 32'd0));
      send_request(button_req(MODE_UNUSED, 4'd15, 1'b1, 4'hF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'hF, 32'd0, 32'hFFFF_FFFF));
      send_request(button_req(MODE_EDGE, 4'd3, 1'b0, 4'h0, 32'hFFFF_FFFF, 32'd0));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'h0, 32'd0, 32'hFFFF_FFFF));
      // several pending, scan stops at the first low one
      send_request(button_req(MODE_EDGE, 4'd0, 1'b0, 4'h0, 32'd120000, 32'd0));
      send_request(button_req(MODE_EDGE, 4'd1, 1'b0, 4'h0, 32'd120000, 32'd0));
      send_request(button_req(MODE_EDGE, 4'd2, 1'b0, 4'h0, 32'd120000, 32'd0));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'b0001, 32'd0, 32'd200));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'h0, 32'd0, 32'd300));
      send_request(button_req(MODE_SET, 4'd1, 1'b1, 4'h0, 32'd0, 32'd0));
      send_request(button_req(MODE_EDGE, 4'd1, 1'b0, 4'h0, 32'd169999, 32'd0));
      send_request(button_req(MODE_EDGE, 4'd1, 1'b0, 4'h0, 32'd170000, 32'd0));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'h0, 32'd0, 32'd249));
      send_request(button_req(MODE_POLL, 4'd0, 1'b0, 4'h0, 32'd0, 32'd250));

      run_phase(32'd200, 32'd20, 1'b0, 250, 1'b0, 1'b0, 1'b0);
      run_phase(32'd0, 32'd0, 1'b1, 250, 1'b1, 1'b0, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 250, 1'b0, 1'b1, 1'b0);
      run_phase(32'd1000, 32'd5, 1'b1, 250, 1'b0, 1'b0, 1'b1);
      run_phase($urandom_range(1, 5000), $urandom_range(1, 100), 1'($urandom_range(0, 1)),
         250, 1'b0, 1'b0, 1'b0);
      run_phase(EDGE_LOCKOUT_US_RESET, PRESS_LOCKOUT_MS_RESET, RELAY_ACTIVE_RESET, 250,
         1'b0, 1'b0, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS multi_channel_button_debounce_relay");
      end else begin
         $display("FAIL multi_channel_button_debounce_relay");
      end
      $finish;
   end

endmodule

[multi_channel_button_debounce_relay.f]
sv/mcdbr_pkg.sv
sv/mcdbr_cell.sv
sv/multi_channel_button_debounce_relay.sv
verif/press_relay_checker.sv
verif/tb_top.sv
